// ===== rtl/mss_pkg.sv =====
// Shared types and opcodes for the string merge sorter.
package mss_pkg;

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b0000_0000_0001,
    ST_RUN   = 12'b0000_0000_0010,
    ST_IDX   = 12'b0000_0000_0100,
    ST_LEN   = 12'b0000_0000_1000,
    ST_LENW  = 12'b0000_0001_0000,
    ST_BYTE  = 12'b0000_0010_0000,
    ST_CHK   = 12'b0000_0100_0000,
    ST_WRITE = 12'b0000_1000_0000,
    ST_R0    = 12'b0001_0000_0000,
    ST_R1    = 12'b0010_0000_0000,
    ST_R2    = 12'b0100_0000_0000,
    ST_ROUT  = 12'b1000_0000_0000
  } mss_state_t;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

endpackage

// ===== rtl/mss_ram.sv =====
// Memory with one write port and two registered read ports.
module mss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== rtl/merge_sort_strings.sv =====
// Top level: name loader, bottom-up merge sort sequencer with bytewise compare, reader.
// Names load at one byte per beat. A read beat stalls input while it walks the index,
// length and name memories and fills the result register; the next read beat is taken
// only once that byte is in the output register, later while out_stall holds it. The
// beat that ends the set starts the sort, which stalls input until done: ceil(log2(n))
// passes, each placing n entries. An entry passes the index, length and write states
// once one run is spent, else also a length wait and a byte fetch and check per byte.
module merge_sort_strings import mss_pkg::*; #(
  parameter int MAX_NAMES  = 256,
  parameter int NAME_BYTES = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_opcode,
  input  logic [7:0] in_name_byte,
  input  logic       in_end_of_name,
  input  logic       in_end_of_set,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_name_end,
  output logic       out_set_end,
  output logic       out_read_status
);

  localparam int CW = $clog2(MAX_NAMES + 1);
  localparam int IW = $clog2(MAX_NAMES);
  localparam int LW = $clog2(NAME_BYTES + 1);
  localparam int PW = $clog2(NAME_BYTES);
  localparam int SW = CW + 2;
  localparam int NA = $clog2(MAX_NAMES * NAME_BYTES);
  localparam int OA = $clog2(2 * MAX_NAMES);

  mss_state_t state_r, state_nxt;
  logic          phase_rd_r, phase_rd_nxt;
  logic [CW-1:0] nl_r, nl_nxt;
  logic [LW-1:0] lpos_r, lpos_nxt;
  logic [CW-1:0] rnp_r, rnp_nxt;
  logic [LW-1:0] rbp_r, rbp_nxt;
  logic [SW-1:0] w_r, w_nxt, lo_r, lo_nxt;
  logic [CW-1:0] mid_r, mid_nxt, hi_r, hi_nxt;
  logic [CW-1:0] a_r, a_nxt, b_r, b_nxt, t_r, t_nxt;
  logic [IW-1:0] xa_r, xa_nxt, xb_r, xb_nxt;
  logic [LW-1:0] la_r, la_nxt, lb_r, lb_nxt, k_r, k_nxt;
  logic          pickb_r, pickb_nxt;
  logic          bank_r, bank_nxt;
  logic [7:0]    res_byte_r, res_byte_nxt;
  logic          res_ne_r, res_ne_nxt, res_se_r, res_se_nxt, res_st_r, res_st_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_byte_r, out_byte_nxt;
  logic          out_ne_r, out_ne_nxt, out_se_r, out_se_nxt, out_st_r, out_st_nxt;

  logic          ord_we, len_we, nm_we;
  logic [OA-1:0] ord_waddr, ord_ra, ord_rb;
  logic [IW-1:0] ord_wdata, ord_da, ord_db;
  logic [IW-1:0] len_waddr, len_ra, len_rb;
  logic [LW-1:0] len_wdata, len_da, len_db;
  logic [NA-1:0] nm_waddr, nm_ra, nm_rb;
  logic [7:0]    nm_da, nm_db;

  logic          acc;
  logic [CW-1:0] eff_nl;
  logic [LW-1:0] eff_lpos, len_new;
  logic [CW-1:0] n_new;
  logic [SW-1:0] lw, l2w, w2;
  logic [LW-1:0] nmin, k1;
  logic          last;

  mss_ram #(.WIDTH(IW), .DEPTH(2 * MAX_NAMES)) u_ord (
    .clk(clk), .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
    .raddr_a(ord_ra), .raddr_b(ord_rb), .rdata_a(ord_da), .rdata_b(ord_db)
  );

  mss_ram #(.WIDTH(LW), .DEPTH(MAX_NAMES)) u_len (
    .clk(clk), .we(len_we), .waddr(len_waddr), .wdata(len_wdata),
    .raddr_a(len_ra), .raddr_b(len_rb), .rdata_a(len_da), .rdata_b(len_db)
  );

  mss_ram #(.WIDTH(8), .DEPTH(MAX_NAMES * NAME_BYTES)) u_name (
    .clk(clk), .we(nm_we), .waddr(nm_waddr), .wdata(in_name_byte),
    .raddr_a(nm_ra), .raddr_b(nm_rb), .rdata_a(nm_da), .rdata_b(nm_db)
  );

  assign in_stall        = (state_r != ST_IDLE);
  assign acc             = in_valid && !in_stall;
  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_name_end    = out_ne_r;
  assign out_set_end     = out_se_r;
  assign out_read_status = out_st_r;

  assign eff_nl   = phase_rd_r ? '0 : nl_r;
  assign eff_lpos = phase_rd_r ? '0 : lpos_r;
  assign len_new  = (eff_lpos < LW'(NAME_BYTES)) ? eff_lpos + 1'b1 : eff_lpos;
  assign n_new    = (eff_nl < CW'(MAX_NAMES)) ? eff_nl + 1'b1 : eff_nl;
  assign lw       = lo_r + w_r;
  assign l2w      = lw + w_r;
  assign w2       = w_r << 1;
  assign nmin     = (la_r < lb_r) ? la_r : lb_r;
  assign k1       = k_r + 1'b1;
  assign last     = (rbp_r + 1'b1) >= len_da;

  // memory ports
  always_comb begin
    ord_we    = 1'b0;
    ord_waddr = {1'b0, eff_nl[IW-1:0]};
    ord_wdata = eff_nl[IW-1:0];
    len_we    = 1'b0;
    len_waddr = eff_nl[IW-1:0];
    len_wdata = len_new;
    nm_we     = 1'b0;
    nm_waddr  = NA'(NA'(eff_nl[IW-1:0]) * NA'(NAME_BYTES)) + NA'(eff_lpos[PW-1:0]);
    ord_ra    = {bank_r, a_r[IW-1:0]};
    ord_rb    = {bank_r, b_r[IW-1:0]};
    len_ra    = ord_da;
    len_rb    = ord_db;
    nm_ra     = NA'(NA'(xa_r) * NA'(NAME_BYTES)) + NA'(k_r[PW-1:0]);
    nm_rb     = NA'(NA'(xb_r) * NA'(NAME_BYTES)) + NA'(k_r[PW-1:0]);
    if (state_r == ST_IDLE && acc && in_opcode == OP_LOAD) begin
      nm_we  = (eff_nl < CW'(MAX_NAMES)) && (eff_lpos < LW'(NAME_BYTES));
      ord_we = in_end_of_name && (eff_nl < CW'(MAX_NAMES));
      len_we = ord_we;
    end
    if (state_r == ST_WRITE) begin
      ord_we    = 1'b1;
      ord_waddr = {~bank_r, t_r[IW-1:0]};
      ord_wdata = pickb_r ? xb_r : xa_r;
    end
    if (state_r == ST_R0 || state_r == ST_R1 || state_r == ST_R2) begin
      ord_ra = {bank_r, rnp_r[IW-1:0]};
      len_ra = ord_da;
      nm_ra  = NA'(NA'(ord_da) * NA'(NAME_BYTES)) + NA'(rbp_r[PW-1:0]);
    end
  end

  always_comb begin
    state_nxt    = state_r;
    phase_rd_nxt = phase_rd_r;
    nl_nxt       = nl_r;
    lpos_nxt     = lpos_r;
    rnp_nxt      = rnp_r;
    rbp_nxt      = rbp_r;
    w_nxt        = w_r;
    lo_nxt       = lo_r;
    mid_nxt      = mid_r;
    hi_nxt       = hi_r;
    a_nxt        = a_r;
    b_nxt        = b_r;
    t_nxt        = t_r;
    xa_nxt       = xa_r;
    xb_nxt       = xb_r;
    la_nxt       = la_r;
    lb_nxt       = lb_r;
    k_nxt        = k_r;
    pickb_nxt    = pickb_r;
    bank_nxt     = bank_r;
    res_byte_nxt = res_byte_r;
    res_ne_nxt   = res_ne_r;
    res_se_nxt   = res_se_r;
    res_st_nxt   = res_st_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_byte_nxt = out_byte_r;
    out_ne_nxt   = out_ne_r;
    out_se_nxt   = out_se_r;
    out_st_nxt   = out_st_r;
    case (state_r)
      ST_IDLE: begin
        if (acc && in_opcode == OP_LOAD) begin
          phase_rd_nxt = 1'b0;
          nl_nxt       = eff_nl;
          lpos_nxt     = len_new;
          if (in_end_of_name) begin
            nl_nxt   = n_new;
            lpos_nxt = '0;
            if (in_end_of_set) begin
              rnp_nxt  = '0;
              rbp_nxt  = '0;
              w_nxt    = SW'(1);
              lo_nxt   = '0;
              bank_nxt = 1'b0;
              if (n_new > CW'(1)) begin
                state_nxt = ST_RUN;
              end else begin
                phase_rd_nxt = 1'b1;
              end
            end
          end
        end else if (acc) begin
          if (phase_rd_r && rnp_r < nl_r) begin
            state_nxt = ST_R0;
          end else begin
            res_byte_nxt = '0;
            res_ne_nxt   = 1'b0;
            res_se_nxt   = 1'b0;
            res_st_nxt   = 1'b1;
            state_nxt    = ST_ROUT;
          end
        end
      end
      ST_RUN: begin
        if (lo_r >= SW'(nl_r)) begin
          bank_nxt = ~bank_r;
          lo_nxt   = '0;
          w_nxt    = w2;
          if (w2 >= SW'(nl_r)) begin
            phase_rd_nxt = 1'b1;
            state_nxt    = ST_IDLE;
          end
        end else begin
          mid_nxt   = (lw < SW'(nl_r)) ? CW'(lw) : nl_r;
          hi_nxt    = (l2w < SW'(nl_r)) ? CW'(l2w) : nl_r;
          a_nxt     = CW'(lo_r);
          b_nxt     = (lw < SW'(nl_r)) ? CW'(lw) : nl_r;
          t_nxt     = CW'(lo_r);
          state_nxt = ST_IDX;
        end
      end
      ST_IDX: begin
        if (a_r >= mid_r && b_r >= hi_r) begin
          lo_nxt    = l2w;
          state_nxt = ST_RUN;
        end else begin
          state_nxt = ST_LEN;
        end
      end
      ST_LEN: begin
        xa_nxt = ord_da;
        xb_nxt = ord_db;
        if (a_r >= mid_r) begin
          pickb_nxt = 1'b1;
          state_nxt = ST_WRITE;
        end else if (b_r >= hi_r) begin
          pickb_nxt = 1'b0;
          state_nxt = ST_WRITE;
        end else begin
          state_nxt = ST_LENW;
        end
      end
      ST_LENW: begin
        la_nxt    = len_da;
        lb_nxt    = len_db;
        k_nxt     = '0;
        state_nxt = ST_BYTE;
      end
      ST_BYTE: begin
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        if (nm_da != nm_db) begin
          pickb_nxt = nm_da > nm_db;
          state_nxt = ST_WRITE;
        end else if (k1 >= nmin) begin
          pickb_nxt = la_r > lb_r;
          state_nxt = ST_WRITE;
        end else begin
          k_nxt     = k1;
          state_nxt = ST_BYTE;
        end
      end
      ST_WRITE: begin
        t_nxt = t_r + 1'b1;
        if (pickb_r) begin
          b_nxt = b_r + 1'b1;
        end else begin
          a_nxt = a_r + 1'b1;
        end
        state_nxt = ST_IDX;
      end
      ST_R0: begin
        state_nxt = ST_R1;
      end
      ST_R1: begin
        state_nxt = ST_R2;
      end
      ST_R2: begin
        res_byte_nxt = nm_da;
        res_ne_nxt   = last;
        res_se_nxt   = last && ((rnp_r + 1'b1) >= nl_r);
        res_st_nxt   = 1'b0;
        state_nxt    = ST_ROUT;
      end
      ST_ROUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = res_byte_r;
          out_ne_nxt    = res_ne_r;
          out_se_nxt    = res_se_r;
          out_st_nxt    = res_st_r;
          if (!res_st_r) begin
            if (res_ne_r) begin
              rnp_nxt = rnp_r + 1'b1;
              rbp_nxt = '0;
            end else begin
              rbp_nxt = rbp_r + 1'b1;
            end
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_rd_r  <= 1'b0;
      nl_r        <= '0;
      lpos_r      <= '0;
      rnp_r       <= '0;
      rbp_r       <= '0;
      out_valid_r <= 1'b0;
      bank_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_rd_r  <= phase_rd_nxt;
      nl_r        <= nl_nxt;
      lpos_r      <= lpos_nxt;
      rnp_r       <= rnp_nxt;
      rbp_r       <= rbp_nxt;
      out_valid_r <= out_valid_nxt;
      bank_r      <= bank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r        <= w_nxt;
    lo_r       <= lo_nxt;
    mid_r      <= mid_nxt;
    hi_r       <= hi_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    t_r        <= t_nxt;
    xa_r       <= xa_nxt;
    xb_r       <= xb_nxt;
    la_r       <= la_nxt;
    lb_r       <= lb_nxt;
    k_r        <= k_nxt;
    pickb_r    <= pickb_nxt;
    res_byte_r <= res_byte_nxt;
    res_ne_r   <= res_ne_nxt;
    res_se_r   <= res_se_nxt;
    res_st_r   <= res_st_nxt;
    out_byte_r <= out_byte_nxt;
    out_ne_r   <= out_ne_nxt;
    out_se_r   <= out_se_nxt;
    out_st_r   <= out_st_nxt;
  end

endmodule
